// ----- hw/rtl/mwa_pkg.sv -----
// shared types, codes and helpers of the multi-width alu
`default_nettype none
package mwa_pkg;

  localparam int unsigned NDiv = 64;

  typedef enum logic [4:0] {
    OP_NOT     = 5'd0,
    OP_AND     = 5'd1,
    OP_OR      = 5'd2,
    OP_XOR     = 5'd3,
    OP_SHL     = 5'd4,
    OP_SAR     = 5'd5,
    OP_SHR     = 5'd6,
    OP_CMP     = 5'd7,
    OP_CMPZERO = 5'd8,
    OP_SETFLAG = 5'd9,
    OP_NEG     = 5'd10,
    OP_ADD     = 5'd11,
    OP_SUB     = 5'd12,
    OP_MUL     = 5'd13,
    OP_DIVS    = 5'd14,
    OP_DIVU    = 5'd15,
    OP_REMS    = 5'd16,
    OP_REMU    = 5'd17
  } op_e;

  localparam logic [7:0] FlagC    = 8'h01;
  localparam logic [7:0] FlagN    = 8'h02;
  localparam logic [7:0] FlagV    = 8'h04;
  localparam logic [7:0] FlagH    = 8'h10;
  localparam logic [7:0] FlagZ    = 8'h40;
  localparam logic [7:0] FlagS    = 8'h80;
  localparam logic [7:0] FlagKeep = 8'h28;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [2:0]  width_sel;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [7:0]  flags_in;
  } req_t;

  typedef struct packed {
    logic [63:0] result;
    logic [7:0]  flags_out;
  } rsp_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic [4:0]  op;
    logic [2:0]  wsel;
    logic        an;
    logic        bn;
    logic        bz;
    logic [63:0] res;
    logic [7:0]  flags;
    logic [63:0] pp0;
    logic [31:0] pp1;
    logic [31:0] pp2;
  } ctl_t;

  // restoring divider state
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] dvd;
    logic [63:0] dvs;
  } div_t;

  function automatic logic [63:0] mask_of(input logic [2:0] wsel);
    logic [63:0] m;
    case (wsel)
      3'd0: m = 64'h0000_0000_0000_00FF;
      3'd1: m = 64'h0000_0000_0000_FFFF;
      3'd2: m = 64'h0000_0000_00FF_FFFF;
      3'd3: m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] width_of(input logic [2:0] wsel);
    logic [6:0] w;
    case (wsel)
      3'd0: w = 7'd8;
      3'd1: w = 7'd16;
      3'd2: w = 7'd24;
      3'd3: w = 7'd32;
      default: w = 7'd64;
    endcase
    return w;
  endfunction

  function automatic logic sign_of(input logic [63:0] v, input logic [2:0] wsel);
    logic s;
    case (wsel)
      3'd0: s = v[7];
      3'd1: s = v[15];
      3'd2: s = v[23];
      3'd3: s = v[31];
      default: s = v[63];
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mwa_front.sv -----
// front stage: operand masking, logic, shift, add/sub/neg, compare and flags, partial products, divider operands
`default_nettype none
module mwa_front (
  input  var mwa_pkg::req_t req_i,
  output mwa_pkg::ctl_t     ctl_o,
  output mwa_pkg::div_t     div_o
);
  logic [63:0] m, a, b, am, bm, d, hm, sfill;
  logic [6:0]  w;
  logic        an, bn, big, sgn;
  logic [5:0]  sh;
  logic [7:0]  fin, cf;
  logic [63:0] cb;

  always_comb begin
    m   = mwa_pkg::mask_of(req_i.width_sel);
    w   = mwa_pkg::width_of(req_i.width_sel);
    a   = req_i.operand_a & m;
    b   = req_i.operand_b & m;
    fin = req_i.flags_in;
    an  = mwa_pkg::sign_of(a, req_i.width_sel);
    bn  = mwa_pkg::sign_of(b, req_i.width_sel);
    am  = an ? ((64'd0 - a) & m) : a;
    bm  = bn ? ((64'd0 - b) & m) : b;
    sh  = b[5:0];
    big = (b >= {57'd0, w});
    sfill = m & ~(m >> sh);
    // compare against b, or against zero
    cb  = (req_i.req_type == mwa_pkg::OP_CMPZERO) ? 64'd0 : b;
    d   = (a - cb) & m;
    hm  = m >> 4;
    cf  = (fin & mwa_pkg::FlagKeep) | mwa_pkg::FlagN;
    if (a < cb) cf = cf | mwa_pkg::FlagC;
    if (mwa_pkg::sign_of((a ^ cb) & (a ^ d), req_i.width_sel)) cf = cf | mwa_pkg::FlagV;
    if ((a & hm) < (cb & hm)) cf = cf | mwa_pkg::FlagH;
    if (a == cb) cf = cf | mwa_pkg::FlagZ;
    if (mwa_pkg::sign_of(d, req_i.width_sel)) cf = cf | mwa_pkg::FlagS;

    ctl_o       = '0;
    ctl_o.op    = req_i.req_type;
    ctl_o.wsel  = req_i.width_sel;
    ctl_o.an    = an;
    ctl_o.bn    = bn;
    ctl_o.bz    = (b == 64'd0);
    ctl_o.flags = fin;
    ctl_o.pp0   = a[31:0] * b[31:0];
    ctl_o.pp1   = 32'(a[31:0] * b[63:32]);
    ctl_o.pp2   = 32'(a[63:32] * b[31:0]);
    sgn = (req_i.req_type == mwa_pkg::OP_DIVS) || (req_i.req_type == mwa_pkg::OP_REMS);
    div_o.rem = '0;
    div_o.dvd = sgn ? am : a;
    div_o.dvs = sgn ? bm : b;

    case (req_i.req_type)
      mwa_pkg::OP_NOT:     ctl_o.res = ~a;
      mwa_pkg::OP_AND:     ctl_o.res = a & b;
      mwa_pkg::OP_OR:      ctl_o.res = a | b;
      mwa_pkg::OP_XOR:     ctl_o.res = a ^ b;
      mwa_pkg::OP_SHL:     ctl_o.res = big ? 64'd0 : (a << sh);
      mwa_pkg::OP_SAR:     ctl_o.res = big ? (an ? m : 64'd0)
                                           : ((a >> sh) | (an ? sfill : 64'd0));
      mwa_pkg::OP_SHR:     ctl_o.res = big ? 64'd0 : (a >> sh);
      mwa_pkg::OP_CMP:     ctl_o.flags = cf;
      mwa_pkg::OP_CMPZERO: ctl_o.flags = cf;
      mwa_pkg::OP_SETFLAG: ctl_o.flags = fin ^ ((fin << 5) & mwa_pkg::FlagS);
      mwa_pkg::OP_NEG:     ctl_o.res = 64'd0 - a;
      mwa_pkg::OP_ADD:     ctl_o.res = a + b;
      mwa_pkg::OP_SUB:     ctl_o.res = a - b;
      default:             ctl_o.res = 64'd0;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mwa_div_step.sv -----
// one restoring division step: one quotient bit
`default_nettype none
module mwa_div_step (
  input  var mwa_pkg::div_t d_i,
  output mwa_pkg::div_t     d_o
);
  logic [64:0] rem_sh;
  logic [65:0] diff;
  logic        borrow;

  always_comb begin
    rem_sh = {d_i.rem, d_i.dvd[63]};
    diff   = {1'b0, rem_sh} - {2'b00, d_i.dvs};
    borrow = diff[65];
    d_o.rem = borrow ? rem_sh[63:0] : diff[63:0];
    d_o.dvd = {d_i.dvd[62:0], ~borrow};
    d_o.dvs = d_i.dvs;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mwa_back.sv -----
// back stage: sign fixup, product sum, result select and width mask
`default_nettype none
module mwa_back (
  input  var mwa_pkg::ctl_t ctl_i,
  input  var mwa_pkg::div_t div_i,
  output mwa_pkg::rsp_t     rsp_o
);
  logic [63:0] m, q, r, nq, nr, prod, res;

  always_comb begin
    m    = mwa_pkg::mask_of(ctl_i.wsel);
    q    = div_i.dvd;
    r    = div_i.rem;
    nq   = 64'd0 - q;
    nr   = 64'd0 - r;
    prod = ctl_i.pp0 + {ctl_i.pp1 + ctl_i.pp2, 32'd0};
    case (ctl_i.op)
      mwa_pkg::OP_MUL:  res = prod;
      mwa_pkg::OP_DIVS: res = ctl_i.bz ? (ctl_i.an ? 64'd1 : m)
                                       : ((ctl_i.an != ctl_i.bn) ? nq : q);
      mwa_pkg::OP_DIVU: res = q;
      mwa_pkg::OP_REMS: res = (ctl_i.bz || !ctl_i.an) ? r : nr;
      mwa_pkg::OP_REMU: res = r;
      default:          res = ctl_i.res;
    endcase
    rsp_o.result    = res & m;
    rsp_o.flags_out = ctl_i.flags;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/multi_width_runtime_alu_core.sv -----
// top level of the multi-width integer alu pipeline
// pipeline: front register, 64 divide step registers, then the output register
// throughput: one transaction per cycle, set by the one-bit-per-stage divider pipeline
// the whole pipeline advances together; it halts only while the output register holds
// a result that is not taken
// reset: rst_ni low clears all valid bits asynchronously; payload registers are not reset
`default_nettype none
module multi_width_runtime_alu_core (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  var mwa_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output mwa_pkg::rsp_t   out_data_o
);
  localparam int unsigned NDiv = mwa_pkg::NDiv;

  // stage 0 is the front register, stage k+1 follows divide step k
  mwa_pkg::ctl_t ctl_q [NDiv+1];
  mwa_pkg::div_t div_q [NDiv+1];
  logic [NDiv:0] v_q;

  mwa_pkg::ctl_t front_ctl;
  mwa_pkg::div_t front_div;
  mwa_pkg::div_t step_div [NDiv];
  mwa_pkg::rsp_t back_rsp;

  mwa_pkg::rsp_t out_q;
  logic          out_valid_q;
  logic          en;

  // global advance: moves whenever the output register is free or being drained
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  mwa_front u_front (
    .req_i (in_data_i),
    .ctl_o (front_ctl),
    .div_o (front_div)
  );

  // divider pipeline, one quotient bit per stage
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    mwa_div_step u_step (
      .d_i (div_q[k]),
      .d_o (step_div[k])
    );
  end

  // front register and all stage registers move together
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= front_ctl;
      div_q[0] <= front_div;
      for (int unsigned k = 0; k < NDiv; k++) begin
        ctl_q[k+1] <= ctl_q[k];
        div_q[k+1] <= step_div[k];
      end
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NDiv-1:0], in_valid_i};
    end
  end

  mwa_back u_back (
    .ctl_i (ctl_q[NDiv]),
    .div_i (div_q[NDiv]),
    .rsp_o (back_rsp)
  );

  // output register parts the pipeline from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= back_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // last stage always lands in the output register when the pipe moves
  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[NDiv] |=> out_valid_o)
    else $error("finished transaction lost before output register");

  // unsigned division leaves a remainder below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NDiv] && (ctl_q[NDiv].op == mwa_pkg::OP_DIVU) && !ctl_q[NDiv].bz
      |-> div_q[NDiv].rem < div_q[NDiv].dvs)
    else $error("divider remainder not below divisor");

  // 8-bit results are zero extended
  a_width8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NDiv] && (ctl_q[NDiv].wsel == 3'd0) |-> back_rsp.result[63:8] == 56'd0)
    else $error("8-bit result not truncated");
`endif

endmodule
`default_nettype wire
